@@ rtl/asq_pkg.sv @@
// asq_pkg: shared types and constants for the analog stick to quadrature unit
// no dependencies; used by every module under rtl
`default_nettype none

package asq_pkg;

   // sample, gain, position, travel, delta, phase and pattern widths
   localparam int SAMPLE_W   = 12;
   localparam int GAIN_W     = 8;
   localparam int POS_W      = 8;
   localparam int TRAVEL_W   = 7;
   localparam int PREV_W     = 9;
   localparam int DELTA_W    = 10;
   localparam int PHASE_W    = 2;
   localparam int PATTERN_W  = 8;

   // parameter defaults
   localparam int SCALE_SHIFT_DEF = 8;
   localparam int MAX_STEPS_DEF   = 64;

   // register file
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_X_GAIN     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_GAIN     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_TRAVEL = 2'd2;

   // reset values
   localparam logic [TRAVEL_W-1:0]  MAX_TRAVEL_RST = 7'd94;
   localparam logic [PATTERN_W-1:0] X_PATTERN_RST  = 8'b1100_1100;
   localparam logic [PATTERN_W-1:0] Y_PATTERN_RST  = 8'b0011_0011;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // one queued word: either the neutral capture or a clamped position pair
   typedef struct packed {
      logic             first;
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
   } entry_type;

endpackage

`default_nettype wire

@@ rtl/asq_front.sv @@
// asq_front: input channel, register file, axis scaling, neutral capture and clamp
// depends on asq_pkg
`default_nettype none

module asq_front #(
   parameter int SCALE_SHIFT = asq_pkg::SCALE_SHIFT_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // input channel
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [asq_pkg::SAMPLE_W-1:0]         req_x_sample,
   input  wire  [asq_pkg::SAMPLE_W-1:0]         req_y_sample,
   // register writes
   input  wire                                  csr_valid,
   input  wire  [asq_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  [asq_pkg::CSR_DATA_W-1:0]       csr_data,
   // queue write side
   input  wire                                  q_full,
   output logic                                 q_push,
   output asq_pkg::entry_type                   q_data
);

   localparam int PROD_W = asq_pkg::SAMPLE_W + asq_pkg::GAIN_W;

   logic [asq_pkg::GAIN_W-1:0]   x_gain_ff, x_gain_in;
   logic [asq_pkg::GAIN_W-1:0]   y_gain_ff, y_gain_in;
   logic [asq_pkg::TRAVEL_W-1:0] max_travel_ff, max_travel_in;
   logic                         neutral_valid_ff, neutral_valid_in;
   logic [asq_pkg::POS_W-1:0]    neutral_x_ff, neutral_x_in;
   logic [asq_pkg::POS_W-1:0]    neutral_y_ff, neutral_y_in;

   logic [PROD_W-1:0]            x_prod, y_prod;
   logic [asq_pkg::POS_W-1:0]    x_scaled, y_scaled;
   logic                         accept;

   // clamp a position to neutral +/- travel
   function automatic logic [asq_pkg::POS_W-1:0] clamp_axis(
      input logic [asq_pkg::POS_W-1:0]    pos,
      input logic [asq_pkg::POS_W-1:0]    neu,
      input logic [asq_pkg::TRAVEL_W-1:0] travel
   );
      logic [asq_pkg::POS_W-1:0] up_dist;
      logic [asq_pkg::POS_W-1:0] dn_dist;
      logic [asq_pkg::POS_W-1:0] result;
      up_dist = pos - neu;
      dn_dist = neu - pos;
      result  = pos;
      if (pos > neu && up_dist > {1'b0, travel}) begin
         result = neu + {1'b0, travel};
      end else if (pos < neu && dn_dist > {1'b0, travel}) begin
         result = neu - {1'b0, travel};
      end
      return result;
   endfunction

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // scale each axis and keep the byte starting at bit SCALE_SHIFT
   assign x_prod   = PROD_W'(req_x_sample) * PROD_W'(x_gain_ff);
   assign y_prod   = PROD_W'(req_y_sample) * PROD_W'(y_gain_ff);
   assign x_scaled = x_prod[SCALE_SHIFT +: asq_pkg::POS_W];
   assign y_scaled = y_prod[SCALE_SHIFT +: asq_pkg::POS_W];

   // register file writes
   always_comb begin
      x_gain_in     = x_gain_ff;
      y_gain_in     = y_gain_ff;
      max_travel_in = max_travel_ff;
      if (csr_valid) begin
         case (csr_index)
            asq_pkg::CSR_X_GAIN:     x_gain_in     = csr_data;
            asq_pkg::CSR_Y_GAIN:     y_gain_in     = csr_data;
            asq_pkg::CSR_MAX_TRAVEL: max_travel_in = csr_data[asq_pkg::TRAVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // classify: first word captures neutral, later words are clamped
   always_comb begin
      neutral_valid_in = neutral_valid_ff;
      neutral_x_in     = neutral_x_ff;
      neutral_y_in     = neutral_y_ff;
      q_push           = accept;
      q_data.first     = !neutral_valid_ff;
      q_data.x         = x_scaled;
      q_data.y         = y_scaled;
      if (neutral_valid_ff) begin
         q_data.x = clamp_axis(x_scaled, neutral_x_ff, max_travel_ff);
         q_data.y = clamp_axis(y_scaled, neutral_y_ff, max_travel_ff);
      end else if (accept) begin
         neutral_valid_in = 1'b1;
         neutral_x_in     = x_scaled;
         neutral_y_in     = y_scaled;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_gain_ff        <= '0;
         y_gain_ff        <= '0;
         max_travel_ff    <= asq_pkg::MAX_TRAVEL_RST;
         neutral_valid_ff <= 1'b0;
         neutral_x_ff     <= '0;
         neutral_y_ff     <= '0;
      end else begin
         x_gain_ff        <= x_gain_in;
         y_gain_ff        <= y_gain_in;
         max_travel_ff    <= max_travel_in;
         neutral_valid_ff <= neutral_valid_in;
         neutral_x_ff     <= neutral_x_in;
         neutral_y_ff     <= neutral_y_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/asq_queue.sv @@
// asq_queue: short fifo of classified words between front and back
// depends on asq_pkg
`default_nettype none

module asq_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  asq_pkg::entry_type  push_data,
   output logic                full,
   input  wire                 pop,
   output asq_pkg::entry_type  pop_data,
   output logic                empty
);

   localparam int PTR_W = $clog2(asq_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(asq_pkg::QUEUE_DEPTH + 1);

   asq_pkg::entry_type   slot_ff [asq_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == CNT_W'(asq_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(asq_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(asq_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/asq_back.sv @@
// asq_back: step sequencer, quadrature patterns and result output register
// depends on asq_pkg
`default_nettype none

module asq_back #(
   parameter int MAX_STEPS = asq_pkg::MAX_STEPS_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   // queue read side
   input  wire                             q_empty,
   input  asq_pkg::entry_type              q_data,
   output logic                            q_pop,
   // result channel
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic [asq_pkg::PHASE_W-1:0]     rsp_x_phase,
   output logic [asq_pkg::PHASE_W-1:0]     rsp_y_phase,
   output logic                            rsp_last_step
);

   localparam int CNT_W = $clog2(MAX_STEPS + 1);

   // one step of a signed delta
   localparam logic signed [asq_pkg::DELTA_W-1:0] ONE_STEP = 1;

   typedef enum logic {
      IDLE,
      STEP
   } state_type;

   state_type                        state_ff, state_in;
   logic [asq_pkg::PREV_W-1:0]       prev_x_ff, prev_x_in;
   logic [asq_pkg::PREV_W-1:0]       prev_y_ff, prev_y_in;
   logic signed [asq_pkg::DELTA_W-1:0] dx_ff, dx_in;
   logic signed [asq_pkg::DELTA_W-1:0] dy_ff, dy_in;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;
   logic [asq_pkg::PATTERN_W-1:0]    x_pat_ff, x_pat_in;
   logic [asq_pkg::PATTERN_W-1:0]    y_pat_ff, y_pat_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [asq_pkg::PHASE_W-1:0]      rsp_x_phase_ff, rsp_x_phase_in;
   logic [asq_pkg::PHASE_W-1:0]      rsp_y_phase_ff, rsp_y_phase_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic                             out_free;
   logic signed [asq_pkg::DELTA_W-1:0] new_dx, new_dy;
   logic                             last;

   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign q_pop         = (state_ff == IDLE) && !q_empty;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_x_phase   = rsp_x_phase_ff;
   assign rsp_y_phase   = rsp_y_phase_ff;
   assign rsp_last_step = rsp_last_ff;

   // deltas of a freshly popped position pair
   assign new_dx = signed'({2'b00, q_data.x}) - signed'({1'b0, prev_x_ff});
   assign new_dy = signed'({2'b00, q_data.y}) - signed'({1'b0, prev_y_ff});

   // sequencer: load deltas, then one step per free output slot
   always_comb begin
      state_in       = state_ff;
      prev_x_in      = prev_x_ff;
      prev_y_in      = prev_y_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      cnt_in         = cnt_ff;
      x_pat_in       = x_pat_ff;
      y_pat_in       = y_pat_ff;
      rsp_x_phase_in = rsp_x_phase_ff;
      rsp_y_phase_in = rsp_y_phase_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      last           = 1'b0;
      case (state_ff)
         IDLE: begin
            if (q_pop) begin
               if (q_data.first) begin
                  prev_x_in = {1'b0, q_data.x};
                  prev_y_in = {1'b0, q_data.y};
               end else if (new_dx != '0 || new_dy != '0) begin
                  dx_in    = new_dx;
                  dy_in    = new_dy;
                  cnt_in   = '0;
                  state_in = STEP;
               end
            end
         end
         STEP: begin
            if (out_free) begin
               // x axis: left for negative, right for positive
               if (dx_ff < 0) begin
                  x_pat_in  = {x_pat_ff[6:0], x_pat_ff[7]};
                  dx_in     = dx_ff + ONE_STEP;
                  prev_x_in = prev_x_ff - 1'b1;
               end else if (dx_ff > 0) begin
                  x_pat_in  = {x_pat_ff[0], x_pat_ff[7:1]};
                  dx_in     = dx_ff - ONE_STEP;
                  prev_x_in = prev_x_ff + 1'b1;
               end
               // y axis
               if (dy_ff > 0) begin
                  y_pat_in  = {y_pat_ff[0], y_pat_ff[7:1]};
                  dy_in     = dy_ff - ONE_STEP;
                  prev_y_in = prev_y_ff + 1'b1;
               end else if (dy_ff < 0) begin
                  y_pat_in  = {y_pat_ff[6:0], y_pat_ff[7]};
                  dy_in     = dy_ff + ONE_STEP;
                  prev_y_in = prev_y_ff - 1'b1;
               end
               last = (dx_in == '0 && dy_in == '0) || (cnt_ff == CNT_W'(MAX_STEPS - 1));
               cnt_in         = cnt_ff + 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_x_phase_in = x_pat_in[1:0];
               rsp_y_phase_in = y_pat_in[7:6];
               rsp_last_in    = last;
               if (last) begin
                  state_in = IDLE;
               end
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         dx_ff        <= '0;
         dy_ff        <= '0;
         cnt_ff       <= '0;
         x_pat_ff     <= asq_pkg::X_PATTERN_RST;
         y_pat_ff     <= asq_pkg::Y_PATTERN_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         dx_ff        <= dx_in;
         dy_ff        <= dy_in;
         cnt_ff       <= cnt_in;
         x_pat_ff     <= x_pat_in;
         y_pat_ff     <= y_pat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_x_phase_ff <= rsp_x_phase_in;
      rsp_y_phase_ff <= rsp_y_phase_in;
      rsp_last_ff    <= rsp_last_in;
   end

endmodule

`default_nettype wire

@@ rtl/analog_stick_to_quadrature_unit.sv @@
// analog_stick_to_quadrature_unit: top level, front, queue and step sequencer
// depends on asq_pkg, asq_front, asq_queue, asq_back
// path of a pair: queue slot, load in IDLE, then STEP writes the result register
// throughput: the sequencer loads a pair in IDLE, then gives one step per cycle
//   while the result side does not stall, up to MAX_STEPS steps per pair, and loads
//   no new pair until the last step; the queue holds 2 pairs
// reset: synchronous, clears control state, registers, neutral capture and patterns
`default_nettype none

module analog_stick_to_quadrature_unit #(
   parameter int SCALE_SHIFT = asq_pkg::SCALE_SHIFT_DEF,
   parameter int MAX_STEPS   = asq_pkg::MAX_STEPS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   // sample pairs in
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [asq_pkg::SAMPLE_W-1:0]      req_x_sample,
   input  wire  [asq_pkg::SAMPLE_W-1:0]      req_y_sample,
   // quadrature steps out
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [asq_pkg::PHASE_W-1:0]       rsp_x_phase,
   output logic [asq_pkg::PHASE_W-1:0]       rsp_y_phase,
   output logic                              rsp_last_step,
   // register writes
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [asq_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [asq_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic               q_full, q_push, q_empty, q_pop;
   asq_pkg::entry_type q_wdata, q_rdata;

   // register writes always taken
   assign csr_ready = 1'b1;

   // front: scale, capture neutral, clamp
   asq_front #(
      .SCALE_SHIFT (SCALE_SHIFT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_x_sample (req_x_sample),
      .req_y_sample (req_y_sample),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_wdata)
   );

   // queue between the halves
   asq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   // back: step sequencer
   asq_back #(
      .MAX_STEPS (MAX_STEPS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_data        (q_rdata),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_x_phase   (rsp_x_phase),
      .rsp_y_phase   (rsp_y_phase),
      .rsp_last_step (rsp_last_step)
   );

endmodule

`default_nettype wire

@@ bench/tb_analog_stick_to_quadrature_unit.sv @@
// tb_analog_stick_to_quadrature_unit: self-checking bench for the stick to quadrature unit
// depends on asq_pkg and analog_stick_to_quadrature_unit; predicts every step word in place
`timescale 1ns / 1ps

module tb_analog_stick_to_quadrature_unit;

   localparam int STUCK_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 16;

   typedef struct packed {
      logic [asq_pkg::SAMPLE_W-1:0] x;
      logic [asq_pkg::SAMPLE_W-1:0] y;
   } sample_pair_type;

   typedef struct packed {
      logic [asq_pkg::PHASE_W-1:0] x_phase;
      logic [asq_pkg::PHASE_W-1:0] y_phase;
      logic                        last_step;
   } step_word_type;

   // clock, reset and block inputs, all known from time zero
   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic [asq_pkg::SAMPLE_W-1:0]    req_x_sample = '0;
   logic [asq_pkg::SAMPLE_W-1:0]    req_y_sample = '0;
   logic                            rsp_stall = 1'b0;
   logic                            csr_valid = 1'b0;
   logic [asq_pkg::CSR_INDEX_W-1:0] csr_index = asq_pkg::CSR_X_GAIN;
   logic [asq_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   // block outputs
   logic                            req_stall;
   logic                            rsp_valid;
   logic [asq_pkg::PHASE_W-1:0]     rsp_x_phase;
   logic [asq_pkg::PHASE_W-1:0]     rsp_y_phase;
   logic                            rsp_last_step;
   logic                            csr_ready;

   // handshake flags, updated at the rising edge
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   logic csr_fire = 1'b0;

   // stimulus bookkeeping
   sample_pair_type pending_pairs[$];
   sample_pair_type next_pair;
   step_word_type   expected_steps[$];
   step_word_type   seen_step;
   int              pairs_sent = 0;
   int              pairs_taken = 0;
   int              mismatches = 0;
   int              stuck_cycles = 0;
   int              gap_left = 0;
   int              stall_left = 0;
   int              last_x = 2048;
   int              last_y = 2048;
   logic            no_idling = 1'b0;

   // predictor copy of registers and stick state
   logic [asq_pkg::GAIN_W-1:0]    x_gain_reg = '0;
   logic [asq_pkg::GAIN_W-1:0]    y_gain_reg = '0;
   logic [asq_pkg::TRAVEL_W-1:0]  travel_reg = asq_pkg::MAX_TRAVEL_RST;
   logic                          have_neutral = 1'b0;
   logic [asq_pkg::POS_W-1:0]     center_x = '0;
   logic [asq_pkg::POS_W-1:0]     center_y = '0;
   logic [asq_pkg::PREV_W-1:0]    last_pos_x = '0;
   logic [asq_pkg::PREV_W-1:0]    last_pos_y = '0;
   logic [asq_pkg::PATTERN_W-1:0] x_wheel = asq_pkg::X_PATTERN_RST;
   logic [asq_pkg::PATTERN_W-1:0] y_wheel = asq_pkg::Y_PATTERN_RST;

   analog_stick_to_quadrature_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_x_sample  (req_x_sample),
      .req_y_sample  (req_y_sample),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_x_phase   (rsp_x_phase),
      .rsp_y_phase   (rsp_y_phase),
      .rsp_last_step (rsp_last_step),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // sample times gain over 256, low 8 bits kept
   function automatic int scale_sample(logic [asq_pkg::SAMPLE_W-1:0] s,
                                       logic [asq_pkg::GAIN_W-1:0] g);
      logic [asq_pkg::SAMPLE_W+asq_pkg::GAIN_W-1:0] prod;
      prod = s * g;
      return int'(prod[asq_pkg::SCALE_SHIFT_DEF +: asq_pkg::POS_W]);
   endfunction

   // keep the position within neutral plus or minus the travel limit
   function automatic int clamp_travel(int pos, int ctr);
      if (pos > ctr && pos - ctr > int'(travel_reg)) return ctr + int'(travel_reg);
      if (pos < ctr && ctr - pos > int'(travel_reg)) return ctr - int'(travel_reg);
      return pos;
   endfunction

   // work out the step words one sample pair causes
   task automatic predict_steps(input logic [asq_pkg::SAMPLE_W-1:0] x_raw, y_raw);
      int xs;
      int ys;
      int dx;
      int dy;
      int n;
      step_word_type w;
      xs = scale_sample(x_raw, x_gain_reg);
      ys = scale_sample(y_raw, y_gain_reg);
      if (!have_neutral) begin
         // first pair only records the neutral point
         have_neutral = 1'b1;
         center_x = xs[asq_pkg::POS_W-1:0];
         center_y = ys[asq_pkg::POS_W-1:0];
         last_pos_x = xs[asq_pkg::PREV_W-1:0];
         last_pos_y = ys[asq_pkg::PREV_W-1:0];
      end else begin
         xs = clamp_travel(xs, int'(center_x));
         ys = clamp_travel(ys, int'(center_y));
         dx = xs - int'(last_pos_x);
         dy = ys - int'(last_pos_y);
         n = 0;
         while ((dx != 0 || dy != 0) && n < asq_pkg::MAX_STEPS_DEF) begin
            if (dx < 0) begin
               x_wheel = {x_wheel[asq_pkg::PATTERN_W-2:0], x_wheel[asq_pkg::PATTERN_W-1]};
               dx++;
               last_pos_x = last_pos_x - 1'b1;
            end else if (dx > 0) begin
               x_wheel = {x_wheel[0], x_wheel[asq_pkg::PATTERN_W-1:1]};
               dx--;
               last_pos_x = last_pos_x + 1'b1;
            end
            if (dy > 0) begin
               y_wheel = {y_wheel[0], y_wheel[asq_pkg::PATTERN_W-1:1]};
               dy--;
               last_pos_y = last_pos_y + 1'b1;
            end else if (dy < 0) begin
               y_wheel = {y_wheel[asq_pkg::PATTERN_W-2:0], y_wheel[asq_pkg::PATTERN_W-1]};
               dy++;
               last_pos_y = last_pos_y - 1'b1;
            end
            w.x_phase   = x_wheel[1:0];
            w.y_phase   = y_wheel[asq_pkg::PATTERN_W-1:asq_pkg::PATTERN_W-2];
            w.last_step = (dx == 0 && dy == 0) || (n == asq_pkg::MAX_STEPS_DEF - 1);
            expected_steps.push_back(w);
            n++;
         end
      end
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // monitor: handshakes, prediction, checking and watchdog
   always @(posedge clock) begin
      req_fire = !reset && req_valid && !req_stall;
      rsp_fire = !reset && rsp_valid && !rsp_stall;
      csr_fire = !reset && csr_valid && csr_ready;
      if (csr_fire) begin
         case (csr_index)
            asq_pkg::CSR_X_GAIN:     x_gain_reg = csr_data;
            asq_pkg::CSR_Y_GAIN:     y_gain_reg = csr_data;
            asq_pkg::CSR_MAX_TRAVEL: travel_reg = csr_data[asq_pkg::TRAVEL_W-1:0];
            default:                 ;
         endcase
      end
      if (req_fire) begin
         predict_steps(req_x_sample, req_y_sample);
         pairs_taken++;
      end
      if (rsp_fire) begin
         if (expected_steps.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word, expected none, actual x %0d y %0d last %0d",
                     $time, rsp_x_phase, rsp_y_phase, rsp_last_step);
         end else begin
            seen_step = expected_steps.pop_front();
            check_field("x_phase", rsp_x_phase, seen_step.x_phase);
            check_field("y_phase", rsp_y_phase, seen_step.y_phase);
            check_field("last_step", rsp_last_step, seen_step.last_step);
         end
      end
      if (req_fire || rsp_fire || csr_fire) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // driver: present queued pairs, with random gaps between them
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fire)) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left = gap_left - 1;
         end else if (pending_pairs.size() > 0) begin
            next_pair = pending_pairs.pop_front();
            req_valid <= 1'b1;
            req_x_sample <= next_pair.x;
            req_y_sample <= next_pair.y;
            if (!no_idling && $urandom_range(3) == 0) gap_left = $urandom_range(1, 10);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side backpressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (!no_idling && $urandom_range(7) == 0) stall_left = $urandom_range(1, 10);
      end
   end

   // one register write, called at a falling edge
   task automatic write_reg(input logic [asq_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [asq_pkg::CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(negedge clock); while (!csr_fire);
   endtask

   task automatic program_regs(input int xg, input int yg, input int travel);
      write_reg(asq_pkg::CSR_X_GAIN, xg[asq_pkg::CSR_DATA_W-1:0]);
      write_reg(asq_pkg::CSR_Y_GAIN, yg[asq_pkg::CSR_DATA_W-1:0]);
      write_reg(asq_pkg::CSR_MAX_TRAVEL, travel[asq_pkg::CSR_DATA_W-1:0]);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_pair(input int x, input int y);
      sample_pair_type p;
      p.x = x[asq_pkg::SAMPLE_W-1:0];
      p.y = y[asq_pkg::SAMPLE_W-1:0];
      last_x = x;
      last_y = y;
      pending_pairs.push_back(p);
      pairs_sent++;
   endtask

   // pick a fresh reading or one near the last, so step counts vary
   function automatic int pick_sample(int prev);
      int v;
      if ($urandom_range(1) == 1) return int'($urandom_range(4095));
      v = prev + int'($urandom_range(400)) - 200;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v;
   endfunction

   // wait until every pair is taken and every word has come back
   task automatic settle();
      while (pairs_taken != pairs_sent || expected_steps.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic run_random(input int n, input int xg, input int yg, input int travel);
      int i;
      program_regs(xg, yg, travel);
      for (i = 0; i < n; i++) queue_pair(pick_sample(last_x), pick_sample(last_y));
      settle();
   endtask

   // stimulus sequence
   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // gain 16 maps the 12-bit reading straight onto 0..255
      program_regs(16, 16, 127);
      queue_pair(2048, 2048);   // neutral capture, no words
      queue_pair(2048, 2048);   // no movement
      queue_pair(2064, 2048);   // one step right on x
      queue_pair(2048, 2032);   // one step back on both axes
      queue_pair(0, 4095);      // clamp low on x, full travel on y, capped
      queue_pair(0, 4095);      // remainder carries over
      queue_pair(0, 4095);
      queue_pair(0, 4095);
      queue_pair(4095, 0);      // far swing the other way
      queue_pair(4095, 0);
      queue_pair(4095, 0);
      queue_pair(4095, 0);
      queue_pair(4095, 0);
      queue_pair(2048, 2048);
      settle();

      // zero travel pins both axes to neutral, y gain zero
      program_regs(255, 0, 0);
      queue_pair(4095, 4095);
      queue_pair(1, 4094);
      queue_pair(2048, 0);
      settle();

      // full gain wraps the scaled value
      program_regs(255, 255, 127);
      queue_pair(4095, 4095);
      queue_pair(1, 1);
      queue_pair(2730, 1365);
      queue_pair(4095, 0);
      queue_pair(0, 4095);
      settle();

      run_random(20, 16, 16, 94);
      run_random(25, 0, 255, 127);
      run_random(30, $urandom_range(255), $urandom_range(255), $urandom_range(127));
      run_random(10, 255, 255, 0);
      run_random(30, $urandom_range(8, 40), $urandom_range(8, 40), $urandom_range(127));

      // closing stretch at full rate
      no_idling = 1'b1;
      run_random(35, 16, 16, 127);

      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ analog_stick_to_quadrature_unit.f @@
rtl/asq_pkg.sv
rtl/asq_front.sv
rtl/asq_queue.sv
rtl/asq_back.sv
rtl/analog_stick_to_quadrature_unit.sv
bench/tb_analog_stick_to_quadrature_unit.sv
